>>> src/lcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcw_pkg: shared types and constants of the lcw decompressor
// Command codes, phase and status encodings, and the records passed
// between the command decoder, the byte stage and the result queue.
// ----------------------------------------------------------------------------
package lcw_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 17;
  localparam int unsigned RunW      = 16;
  localparam int unsigned TdataOutW = 32;
  localparam int unsigned TuserOutW = 5;

  // result queue
  localparam int unsigned OfifoDepth = 4;
  localparam int unsigned OfifoPtrW  = $clog2(OfifoDepth);
  localparam int unsigned OfifoCntW  = $clog2(OfifoDepth + 1);

  // command byte decoding
  localparam logic [7:0] CmdFill   = 8'hFE;
  localparam logic [7:0] CmdLong   = 8'hFF;
  localparam logic [5:0] LenMask   = 6'h3F;
  localparam logic [3:0] ShortHiMask = 4'hF;
  localparam logic [15:0] CountBias = 16'd3;

  typedef enum logic [6:0] {
    PH_CMD = 7'b0000001,
    PH_OPA = 7'b0000010,
    PH_OPB = 7'b0000100,
    PH_OPC = 7'b0001000,
    PH_OPD = 7'b0010000,
    PH_LIT = 7'b0100000,
    PH_RUN = 7'b1000000
  } phase_e;

  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_SHORT = 3'd1,
    K_LIT   = 3'd2,
    K_MED   = 3'd3,
    K_FILL  = 3'd4,
    K_LONG  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BYTE    = 3'd1,
    ST_END     = 3'd2,
    ST_LIMIT   = 3'd3,
    ST_BADOFF  = 3'd4,
    ST_REFUSED = 3'd5
  } status_e;

  // decoded item, byte value still open when it comes from the history
  typedef struct packed {
    logic              out_valid;
    logic              use_mem;
    logic [ByteW-1:0]  byte_val;
    status_e           status;
    logic [CountW-1:0] wcount;
    logic              done;
  } step_t;

  // finished result beat
  typedef struct packed {
    logic              done;
    status_e           status;
    logic              out_valid;
    logic [CountW-1:0] wcount;
    logic [ByteW-1:0]  out_byte;
  } result_t;

endpackage

>>> src/lcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcw_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lcw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcw_ctrl: command decoder and run sequencer
// Parses command and operand bytes, tracks the pending copy or fill,
// checks offsets and the output limit, and issues history reads.
// ----------------------------------------------------------------------------
module lcw_ctrl #(
  parameter int unsigned HISTORY_DEPTH = 65536,
  localparam int unsigned AddrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [lcw_pkg::CountW-1:0] cfg_data_i,
  input  logic                      acc_i,
  input  logic                      mode_i,
  input  logic [lcw_pkg::ByteW-1:0] data_i,
  output lcw_pkg::step_t            step_o,
  output logic                      rd_en_o,
  output logic [AddrW-1:0]          rd_addr_o
);

  localparam logic [lcw_pkg::CountW-1:0] DepthC = lcw_pkg::CountW'(HISTORY_DEPTH);
  localparam logic [lcw_pkg::CountW-1:0] LimitRst = lcw_pkg::CountW'(65536);

  logic [lcw_pkg::CountW-1:0] limit_q, limit_d;
  logic [lcw_pkg::CountW-1:0] wc_q, wc_d;
  lcw_pkg::phase_e            phase_q, phase_d;
  lcw_pkg::kind_e             kind_q, kind_d;
  logic [lcw_pkg::RunW-1:0]   rc_q, rc_d;
  logic [AddrW-1:0]           cs_q, cs_d;
  logic [lcw_pkg::ByteW-1:0]  fv_q, fv_d;
  logic [lcw_pkg::ByteW-1:0]  olow_q, olow_d;
  logic                       fin_q, fin_d;

  logic [lcw_pkg::CountW-1:0] eff_limit;
  logic [lcw_pkg::RunW-1:0]   off_short;
  logic [lcw_pkg::RunW-1:0]   off_abs;
  logic                       emit;
  lcw_pkg::step_t             step;

  assign eff_limit = (limit_q > DepthC) ? DepthC : limit_q;
  assign off_short = {olow_q, data_i};
  assign off_abs   = {data_i, olow_q};

  always_comb begin
    limit_d = cfg_valid_i ? cfg_data_i : limit_q;
    wc_d    = wc_q;
    phase_d = phase_q;
    kind_d  = kind_q;
    rc_d    = rc_q;
    cs_d    = cs_q;
    fv_d    = fv_q;
    olow_d  = olow_q;
    fin_d   = fin_q;
    emit    = 1'b0;
    step    = '0;
    step.status = lcw_pkg::ST_OK;

    if (acc_i) begin
      if (fin_q) begin
        step.status = lcw_pkg::ST_REFUSED;
      end else if (wc_q >= eff_limit) begin
        fin_d = 1'b1;
        step.status = lcw_pkg::ST_LIMIT;
      end else if (mode_i) begin
        if (phase_q != lcw_pkg::PH_RUN) begin
          step.status = lcw_pkg::ST_REFUSED;
        end else begin
          step.use_mem  = (kind_q != lcw_pkg::K_FILL);
          step.byte_val = (kind_q == lcw_pkg::K_FILL) ? fv_q : '0;
          cs_d = cs_q + AddrW'(1);
          rc_d = rc_q - 16'd1;
          if (rc_q == 16'd1) begin
            phase_d = lcw_pkg::PH_CMD;
          end
          emit = 1'b1;
        end
      end else if (phase_q == lcw_pkg::PH_RUN) begin
        step.status = lcw_pkg::ST_REFUSED;
      end else begin
        case (phase_q)
          lcw_pkg::PH_OPA: begin
            if (kind_q == lcw_pkg::K_SHORT) begin
              if (off_short == '0 || {1'b0, off_short} > wc_q) begin
                fin_d = 1'b1;
                step.status = lcw_pkg::ST_BADOFF;
              end else begin
                cs_d    = AddrW'(wc_q - {1'b0, off_short});
                phase_d = lcw_pkg::PH_RUN;
              end
            end else begin
              olow_d  = data_i;
              phase_d = lcw_pkg::PH_OPB;
            end
          end
          lcw_pkg::PH_OPB: begin
            if (kind_q == lcw_pkg::K_MED) begin
              if ({1'b0, off_abs} >= wc_q) begin
                fin_d = 1'b1;
                step.status = lcw_pkg::ST_BADOFF;
              end else begin
                cs_d    = off_abs[AddrW-1:0];
                phase_d = lcw_pkg::PH_RUN;
              end
            end else begin
              rc_d    = off_abs;
              phase_d = lcw_pkg::PH_OPC;
            end
          end
          lcw_pkg::PH_OPC: begin
            if (kind_q == lcw_pkg::K_FILL) begin
              fv_d    = data_i;
              phase_d = (rc_q != '0) ? lcw_pkg::PH_RUN : lcw_pkg::PH_CMD;
            end else begin
              olow_d  = data_i;
              phase_d = lcw_pkg::PH_OPD;
            end
          end
          lcw_pkg::PH_OPD: begin
            // empty long copy skips the offset check
            if (rc_q == '0) begin
              phase_d = lcw_pkg::PH_CMD;
            end else if ({1'b0, off_abs} >= wc_q) begin
              fin_d = 1'b1;
              step.status = lcw_pkg::ST_BADOFF;
            end else begin
              cs_d    = off_abs[AddrW-1:0];
              phase_d = lcw_pkg::PH_RUN;
            end
          end
          lcw_pkg::PH_LIT: begin
            step.byte_val = data_i;
            rc_d = rc_q - 16'd1;
            if (rc_q == 16'd1) begin
              phase_d = lcw_pkg::PH_CMD;
            end
            emit = 1'b1;
          end
          default: begin
            phase_d = lcw_pkg::PH_CMD;
            if (!data_i[7]) begin
              kind_d  = lcw_pkg::K_SHORT;
              rc_d    = {13'd0, data_i[6:4]} + lcw_pkg::CountBias;
              olow_d  = {4'd0, data_i[3:0] & lcw_pkg::ShortHiMask};
              phase_d = lcw_pkg::PH_OPA;
            end else if (!data_i[6]) begin
              if ((data_i[5:0] & lcw_pkg::LenMask) == '0) begin
                // end of data marker
                fin_d = 1'b1;
                step.status = lcw_pkg::ST_END;
              end else begin
                kind_d  = lcw_pkg::K_LIT;
                rc_d    = {10'd0, data_i[5:0]};
                phase_d = lcw_pkg::PH_LIT;
              end
            end else if (data_i == lcw_pkg::CmdFill) begin
              kind_d  = lcw_pkg::K_FILL;
              phase_d = lcw_pkg::PH_OPA;
            end else if (data_i == lcw_pkg::CmdLong) begin
              kind_d  = lcw_pkg::K_LONG;
              phase_d = lcw_pkg::PH_OPA;
            end else begin
              kind_d  = lcw_pkg::K_MED;
              rc_d    = {10'd0, data_i[5:0]} + lcw_pkg::CountBias;
              phase_d = lcw_pkg::PH_OPA;
            end
          end
        endcase
      end

      if (emit) begin
        step.out_valid = 1'b1;
        wc_d = wc_q + lcw_pkg::CountW'(1);
        if (wc_d >= eff_limit) begin
          fin_d = 1'b1;
          step.status = lcw_pkg::ST_LIMIT;
        end else begin
          step.status = lcw_pkg::ST_BYTE;
        end
      end
      step.wcount = wc_d;
      step.done   = fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitRst;
      wc_q    <= '0;
      phase_q <= lcw_pkg::PH_CMD;
      kind_q  <= lcw_pkg::K_NONE;
      rc_q    <= '0;
      cs_q    <= '0;
      fv_q    <= '0;
      olow_q  <= '0;
      fin_q   <= 1'b0;
    end else begin
      limit_q <= limit_d;
      wc_q    <= wc_d;
      phase_q <= phase_d;
      kind_q  <= kind_d;
      rc_q    <= rc_d;
      cs_q    <= cs_d;
      fv_q    <= fv_d;
      olow_q  <= olow_d;
      fin_q   <= fin_d;
    end
  end

  assign step_o    = step;
  assign rd_en_o   = acc_i & mode_i;
  assign rd_addr_o = cs_q;

endmodule

>>> src/lcw_ofifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcw_ofifo: result queue
// Small register queue decoupling the byte stage from the output stall.
// ----------------------------------------------------------------------------
module lcw_ofifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  lcw_pkg::result_t              push_data_i,
  input  logic                          pop_i,
  output lcw_pkg::result_t              head_o,
  output logic [lcw_pkg::OfifoCntW-1:0] cnt_o
);

  lcw_pkg::result_t                entry_q [lcw_pkg::OfifoDepth];
  logic [lcw_pkg::OfifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [lcw_pkg::OfifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [lcw_pkg::OfifoCntW-1:0]   cnt_q, cnt_d;
  logic                            do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + lcw_pkg::OfifoPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + lcw_pkg::OfifoPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + lcw_pkg::OfifoCntW'(push_i) - lcw_pkg::OfifoCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o = entry_q[rd_ptr_q];
  assign cnt_o  = cnt_q;

endmodule

>>> src/lcw_decompressor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcw_decompressor_top: lcw (format 80) stream decompressor
// Decodes compressed bytes into a history ram and returns one result beat
// for every input beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per item, tuser = mode (0 feed byte, 1 pull byte),
//   tdata = compressed byte. m_axis: one result beat per input beat, in
//   order. cfg: write of the output limit, always ready, only while idle.
//   Path: a beat is decoded and its history read issued as it is accepted;
//   the byte stage stores the output byte and pushes the result into the
//   result queue, from which it is presented.
//   Throughput: one beat per cycle while s_axis_tready is high; the history
//   ram has one read and one write port, and a copy reading the byte stored in
//   the same cycle takes it from a bypass register instead of the ram.
//   Stall: a four-deep result queue absorbs receiver stalls; s_axis_tready
//   drops once the queue plus the beat in flight fill it, so nothing is
//   lost. Reset clears all control state and the queue; the history ram
//   is not cleared and needs no clearing pass, since offsets are checked
//   against the number of bytes already written.
// ----------------------------------------------------------------------------
module lcw_decompressor_top #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lcw_pkg::CountW-1:0]      cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // data_byte
  input  logic                            s_axis_tuser,   // mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_byte [7:0], bytes_written [24:8], zero pad
  output logic [lcw_pkg::TdataOutW-1:0]   m_axis_tdata,
  // out_valid [0], status [3:1], done_res [4]
  output logic [lcw_pkg::TuserOutW-1:0]   m_axis_tuser
);

  localparam int unsigned AddrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned PadW  = lcw_pkg::TdataOutW - lcw_pkg::CountW - lcw_pkg::ByteW;

  logic                          s_acc;
  lcw_pkg::step_t                step;
  logic                          rd_en;
  logic [AddrW-1:0]              rd_addr;
  logic [lcw_pkg::ByteW-1:0]     rd_data;

  logic                          p_valid_q;
  lcw_pkg::step_t                p_q;
  logic                          fwd_q, fwd_d;
  logic [lcw_pkg::ByteW-1:0]     fwd_byte_q;
  logic [lcw_pkg::ByteW-1:0]     p_byte;
  logic [lcw_pkg::CountW-1:0]    p_wpos;
  logic [AddrW-1:0]              p_waddr;
  logic                          p_we;

  lcw_pkg::result_t              push_data;
  lcw_pkg::result_t              head;
  logic [lcw_pkg::OfifoCntW-1:0] fifo_cnt;
  logic [lcw_pkg::OfifoCntW-1:0] occ;

  assign cfg_ready_o = 1'b1;

  assign occ           = fifo_cnt + lcw_pkg::OfifoCntW'(p_valid_q);
  assign s_axis_tready = (occ < lcw_pkg::OfifoCntW'(lcw_pkg::OfifoDepth));
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  lcw_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (s_acc),
    .mode_i     (s_axis_tuser),
    .data_i     (s_axis_tdata),
    .step_o     (step),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr)
  );

  // byte stage: resolve history data and store the output byte
  assign p_wpos  = p_q.wcount - lcw_pkg::CountW'(1);
  assign p_waddr = p_wpos[AddrW-1:0];
  assign p_we    = p_valid_q & p_q.out_valid;

  always_comb begin
    if (!p_q.out_valid) begin
      p_byte = '0;
    end else if (p_q.use_mem) begin
      p_byte = fwd_q ? fwd_byte_q : rd_data;
    end else begin
      p_byte = p_q.byte_val;
    end
  end

  // read of the entry being stored this cycle gets the stored byte
  assign fwd_d = p_we && (rd_addr == p_waddr);

  lcw_ram #(
    .Width(lcw_pkg::ByteW),
    .Depth(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_byte),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= s_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= step;
    fwd_q      <= fwd_d;
    fwd_byte_q <= p_byte;
  end

  always_comb begin
    push_data.done      = p_q.done;
    push_data.status    = p_q.status;
    push_data.out_valid = p_q.out_valid;
    push_data.wcount    = p_q.wcount;
    push_data.out_byte  = p_byte;
  end

  lcw_ofifo u_ofifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (p_valid_q),
    .push_data_i(push_data),
    .pop_i      (m_axis_tready),
    .head_o     (head),
    .cnt_o      (fifo_cnt)
  );

  assign m_axis_tvalid = (fifo_cnt != '0);
  assign m_axis_tdata  = {{PadW{1'b0}}, head.wcount, head.out_byte};
  assign m_axis_tuser  = {head.done, head.status, head.out_valid};

  // the beat in flight always finds room in the result queue
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> (fifo_cnt < lcw_pkg::OfifoCntW'(lcw_pkg::OfifoDepth)))
    else $error("result queue overflow");

  // every accepted beat reaches the byte stage on the next edge
  a_stage_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> p_valid_q)
    else $error("accepted beat lost before byte stage");

  // a byte is only given with byte or limit status
  a_byte_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_we |-> (p_q.status == lcw_pkg::ST_BYTE || p_q.status == lcw_pkg::ST_LIMIT))
    else $error("output byte with wrong status");

endmodule

>>> verif/lcw_decompressor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcw_decompressor_top_tb: self-checking bench for the lcw decompressor
// Sends compressed command streams and pull beats, predicts every result
// beat with a behavioral decoder and its own history copy, and checks each
// output beat field by field under several idle, stall and limit settings.
// ----------------------------------------------------------------------------
module lcw_decompressor_top_tb;

  localparam int unsigned HistDepth     = 65536;
  localparam int unsigned TimeoutCycles = 400000;
  localparam logic [7:0]  CmdLitBase    = 8'h80;  // also the end marker
  localparam logic [7:0]  CmdMedBase    = 8'hC0;
  localparam logic        ModeFeed      = 1'b0;
  localparam logic        ModePull      = 1'b1;

  typedef enum int {
    END_MARKER,
    END_LIMIT_BYTE,
    END_LIMIT_CFG,
    END_SHORT_OFF,
    END_ABS_OFF
  } stop_e;

  typedef struct packed {
    logic             out_valid;
    logic [7:0]       out_byte;
    lcw_pkg::status_e status;
    logic [16:0]      count;
    logic             done;
  } beat_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [lcw_pkg::CountW-1:0]    cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [lcw_pkg::TdataOutW-1:0] m_axis_tdata;
  logic [lcw_pkg::TuserOutW-1:0] m_axis_tuser;

  // decoder model state
  logic [7:0]      hist_mem [HistDepth];
  logic [16:0]     dec_count;
  logic [16:0]     dec_limit;
  lcw_pkg::phase_e dec_phase;
  lcw_pkg::kind_e  dec_kind;
  logic [15:0]     dec_run;
  logic [15:0]     dec_src;
  logic [7:0]      dec_fill;
  logic [7:0]      dec_lo;
  logic            dec_done;

  beat_t       pending_beats [$];
  int unsigned beats_sent    = 0;
  int unsigned refused_beats = 0;
  int unsigned beats_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_stall_pct  = 0;
  int unsigned hold_len      = 0;
  stop_e       stop_kind     = END_MARKER;

  always #4 clk_i = ~clk_i;

  lcw_decompressor_top #(
    .HISTORY_DEPTH(HistDepth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // ---------------------------------------------------------------- model

  function automatic logic [16:0] limit_cap();
    return (dec_limit > 17'(HistDepth)) ? 17'(HistDepth) : dec_limit;
  endfunction

  function automatic lcw_pkg::status_e store_byte(input logic [7:0] b);
    if (dec_count < 17'(HistDepth)) hist_mem[dec_count[15:0]] = b;
    dec_count = dec_count + 17'd1;
    if (dec_count >= limit_cap()) begin
      dec_done = 1'b1;
      return lcw_pkg::ST_LIMIT;
    end
    return lcw_pkg::ST_BYTE;
  endfunction

  function automatic lcw_pkg::status_e start_abs_copy(input logic [15:0] off);
    if (17'(off) >= dec_count) begin
      dec_done = 1'b1;
      return lcw_pkg::ST_BADOFF;
    end
    dec_src   = off;
    dec_phase = lcw_pkg::PH_RUN;
    return lcw_pkg::ST_OK;
  endfunction

  function automatic beat_t decode_beat(input logic mode, input logic [7:0] b);
    beat_t       r;
    logic [11:0] off;
    logic [7:0]  v;
    r = '0;
    r.status = lcw_pkg::ST_OK;
    if (dec_done) begin
      r.status = lcw_pkg::ST_REFUSED;
    end else if (dec_count >= limit_cap()) begin
      dec_done = 1'b1;
      r.status = lcw_pkg::ST_LIMIT;
    end else if (mode == ModePull) begin
      if (dec_phase != lcw_pkg::PH_RUN) begin
        r.status = lcw_pkg::ST_REFUSED;
      end else begin
        v = (dec_kind == lcw_pkg::K_FILL) ? dec_fill : hist_mem[dec_src];
        dec_src = dec_src + 16'd1;
        dec_run = dec_run - 16'd1;
        if (dec_run == 16'd0) dec_phase = lcw_pkg::PH_CMD;
        r.out_valid = 1'b1;
        r.out_byte  = v;
        r.status    = store_byte(v);
      end
    end else if (dec_phase == lcw_pkg::PH_RUN) begin
      r.status = lcw_pkg::ST_REFUSED;
    end else begin
      case (dec_phase)
        lcw_pkg::PH_OPA: begin
          if (dec_kind == lcw_pkg::K_SHORT) begin
            off = {dec_lo[3:0], b};
            if (off == 12'd0 || 17'(off) > dec_count) begin
              dec_done = 1'b1;
              r.status = lcw_pkg::ST_BADOFF;
            end else begin
              dec_src   = 16'(dec_count - 17'(off));
              dec_phase = lcw_pkg::PH_RUN;
            end
          end else begin
            dec_lo    = b;
            dec_phase = lcw_pkg::PH_OPB;
          end
        end
        lcw_pkg::PH_OPB: begin
          if (dec_kind == lcw_pkg::K_MED) begin
            r.status = start_abs_copy({b, dec_lo});
          end else begin
            dec_run   = {b, dec_lo};
            dec_phase = lcw_pkg::PH_OPC;
          end
        end
        lcw_pkg::PH_OPC: begin
          if (dec_kind == lcw_pkg::K_FILL) begin
            dec_fill = b;
            if (dec_run != 16'd0) dec_phase = lcw_pkg::PH_RUN;
            else dec_phase = lcw_pkg::PH_CMD;
          end else begin
            dec_lo    = b;
            dec_phase = lcw_pkg::PH_OPD;
          end
        end
        lcw_pkg::PH_OPD: begin
          if (dec_run == 16'd0) dec_phase = lcw_pkg::PH_CMD;
          else r.status = start_abs_copy({b, dec_lo});
        end
        lcw_pkg::PH_LIT: begin
          r.out_valid = 1'b1;
          r.out_byte  = b;
          dec_run = dec_run - 16'd1;
          if (dec_run == 16'd0) dec_phase = lcw_pkg::PH_CMD;
          r.status = store_byte(b);
        end
        default: begin
          dec_phase = lcw_pkg::PH_CMD;
          if (!b[7]) begin
            dec_kind  = lcw_pkg::K_SHORT;
            dec_run   = 16'(b[6:4]) + lcw_pkg::CountBias;
            dec_lo    = {4'h0, b[3:0]};
            dec_phase = lcw_pkg::PH_OPA;
          end else if (!b[6]) begin
            if (b[5:0] == 6'd0) begin
              dec_done = 1'b1;
              r.status = lcw_pkg::ST_END;
            end else begin
              dec_kind  = lcw_pkg::K_LIT;
              dec_run   = 16'(b[5:0]);
              dec_phase = lcw_pkg::PH_LIT;
            end
          end else if (b == lcw_pkg::CmdFill) begin
            dec_kind  = lcw_pkg::K_FILL;
            dec_phase = lcw_pkg::PH_OPA;
          end else if (b == lcw_pkg::CmdLong) begin
            dec_kind  = lcw_pkg::K_LONG;
            dec_phase = lcw_pkg::PH_OPA;
          end else begin
            dec_kind  = lcw_pkg::K_MED;
            dec_run   = 16'(b[5:0]) + lcw_pkg::CountBias;
            dec_phase = lcw_pkg::PH_OPA;
          end
        end
      endcase
    end
    r.count = dec_count;
    r.done  = dec_done;
    return r;
  endfunction

  // ------------------------------------------------------------- drivers

  task automatic send_beat(input logic mode, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_beats.push_back(decode_beat(mode, b));
    beats_sent++;
    if (pending_beats[$].status == lcw_pkg::ST_REFUSED) refused_beats++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [16:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    dec_limit = value;
  endtask

  // pull out a pending copy or fill, sometimes poking a feed in between
  task automatic pull_run(input int unsigned noise_pct);
    while (dec_phase == lcw_pkg::PH_RUN && !dec_done) begin
      if ($urandom_range(99) < noise_pct) send_beat(ModeFeed, 8'($urandom));
      else send_beat(ModePull, 8'($urandom));
    end
  endtask

  function automatic logic [15:0] pick_count();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'($urandom_range(300, 40));
      default: return 16'($urandom_range(24, 1));
    endcase
  endfunction

  task automatic send_random_command();
    logic [7:0]  cmd_bytes [$];
    logic [15:0] n;
    logic [15:0] off;
    logic [11:0] soff;
    int unsigned smax;
    int unsigned pick;
    pick = $urandom_range(99);
    if (dec_count == 17'd0) pick = 0;
    smax = (dec_count > 17'd4095) ? 4095 : int'(dec_count);
    if (pick < 30) begin
      n = ($urandom_range(3) == 0) ? 16'($urandom_range(63, 1))
                                   : 16'($urandom_range(8, 1));
      cmd_bytes.push_back(CmdLitBase | 8'(n));
      repeat (n) cmd_bytes.push_back(8'($urandom));
    end else if (pick < 55) begin
      // small offsets overlap the copy with its own output
      if ($urandom_range(1) == 0) soff = 12'($urandom_range((smax > 4) ? 4 : smax, 1));
      else soff = 12'($urandom_range(smax, 1));
      cmd_bytes.push_back({1'b0, 3'($urandom_range(7)), soff[11:8]});
      cmd_bytes.push_back(soff[7:0]);
    end else if (pick < 70) begin
      off = 16'($urandom_range(int'(dec_count) - 1));
      cmd_bytes.push_back(CmdMedBase | 8'($urandom_range(61)));
      cmd_bytes.push_back(off[7:0]);
      cmd_bytes.push_back(off[15:8]);
    end else if (pick < 85) begin
      n = pick_count();
      cmd_bytes.push_back(lcw_pkg::CmdFill);
      cmd_bytes.push_back(n[7:0]);
      cmd_bytes.push_back(n[15:8]);
      cmd_bytes.push_back(8'($urandom));
    end else begin
      n = pick_count();
      // an empty long copy never checks its offset
      if (n == 16'd0) off = 16'($urandom);
      else off = 16'($urandom_range(int'(dec_count) - 1));
      cmd_bytes.push_back(lcw_pkg::CmdLong);
      cmd_bytes.push_back(n[7:0]);
      cmd_bytes.push_back(n[15:8]);
      cmd_bytes.push_back(off[7:0]);
      cmd_bytes.push_back(off[15:8]);
    end
    foreach (cmd_bytes[i]) begin
      if (dec_done) return;
      if ($urandom_range(99) < 3) send_beat(ModePull, 8'($urandom));
      send_beat(ModeFeed, cmd_bytes[i]);
    end
    pull_run(4);
  endtask

  // -------------------------------------------------------------- tests

  task automatic test_basic_commands();
    send_beat(ModePull, 8'h00);                 // nothing pending yet
    send_beat(ModeFeed, CmdLitBase | 8'd3);
    send_beat(ModeFeed, 8'h00);
    send_beat(ModeFeed, 8'hFF);
    send_beat(ModeFeed, 8'h5A);
    send_beat(ModeFeed, 8'h00);                 // short copy of 3, one back
    send_beat(ModeFeed, 8'h01);
    send_beat(ModeFeed, CmdLitBase);            // refused while the copy is open
    pull_run(0);
    send_beat(ModeFeed, CmdMedBase);
    send_beat(ModeFeed, 8'h01);
    send_beat(ModeFeed, 8'h00);
    pull_run(0);
    send_beat(ModeFeed, lcw_pkg::CmdFill);
    send_beat(ModeFeed, 8'h01);
    send_beat(ModeFeed, 8'h00);
    send_beat(ModeFeed, 8'hAB);
    pull_run(0);
    send_beat(ModeFeed, lcw_pkg::CmdLong);
    send_beat(ModeFeed, 8'h01);
    send_beat(ModeFeed, 8'h00);
    send_beat(ModeFeed, 8'h00);
    send_beat(ModeFeed, 8'h00);
    pull_run(0);
  endtask

  task automatic test_random_stream(input int unsigned items, input int unsigned tx_pct,
                                    input int unsigned rx_pct, input logic [16:0] limit);
    int unsigned target;
    write_limit(limit);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    target = beats_sent - refused_beats + items;
    while (beats_sent - refused_beats < target && !dec_done) send_random_command();
    wait_drained();
  endtask

  // sink holds off long enough for the result queue to fill and stall the input
  task automatic test_backpressure();
    wait_drained();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_len     = 300;
    test_random_stream(150, 0, 0, 17'h1FFFF);
  endtask

  task automatic test_end_of_stream();
    logic [11:0] soff;
    logic [15:0] aoff;
    tx_idle_pct  = 17;
    rx_stall_pct = 17;
    stop_kind = stop_e'($urandom_range(4));
    case (stop_kind)
      END_MARKER: begin
        send_beat(ModeFeed, CmdLitBase);
      end
      END_LIMIT_BYTE: begin
        write_limit(dec_count + 17'($urandom_range(40, 1)));
        send_beat(ModeFeed, lcw_pkg::CmdFill);
        send_beat(ModeFeed, 8'hFF);
        send_beat(ModeFeed, 8'hFF);
        send_beat(ModeFeed, 8'($urandom));
        pull_run(10);
      end
      END_LIMIT_CFG: begin
        write_limit(17'd0);
        send_beat(1'($urandom), 8'($urandom));
      end
      END_SHORT_OFF: begin
        if ($urandom_range(1) == 0 || dec_count >= 17'd4095) soff = 12'd0;
        else soff = 12'($urandom_range(4095, int'(dec_count) + 1));
        send_beat(ModeFeed, {1'b0, 3'($urandom_range(7)), soff[11:8]});
        send_beat(ModeFeed, soff[7:0]);
      end
      default: begin
        aoff = 16'($urandom_range(65535, int'(dec_count)));
        send_beat(ModeFeed, CmdMedBase | 8'($urandom_range(61)));
        send_beat(ModeFeed, aoff[7:0]);
        send_beat(ModeFeed, aoff[15:8]);
      end
    endcase
    repeat (8) send_beat(1'($urandom), 8'($urandom));
    wait_drained();
  endtask

  // ------------------------------------------------------ sink and checks

  initial begin : rx_side
    int unsigned held;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        m_axis_tready <= 1'b0;
        for (held = 0; held < hold_len; held++) @(posedge clk_i);
        hold_len = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic flag_mismatch(input string what, input beat_t want, input beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch %0d (%s): exp v%0b b%02h st%0d n%0d d%0b, ",
                "got v%0b b%02h st%0d n%0d d%0b"},
               mismatches, what, want.out_valid, want.out_byte, want.status, want.count,
               want.done, got.out_valid, got.out_byte, got.status, got.count, got.done);
  endtask

  always @(posedge clk_i) begin : result_check
    beat_t got;
    beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.out_byte  = m_axis_tdata[7:0];
      got.count     = m_axis_tdata[24:8];
      got.out_valid = m_axis_tuser[0];
      got.status    = lcw_pkg::status_e'(m_axis_tuser[3:1]);
      got.done      = m_axis_tuser[4];
      beats_checked++;
      if (pending_beats.size() == 0) begin
        flag_mismatch("nothing expected", '0, got);
      end else begin
        want = pending_beats.pop_front();
        if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
            got.status !== want.status || got.count !== want.count ||
            got.done !== want.done)
          flag_mismatch("wrong field", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TimeoutCycles) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               pending_beats.size());
      $display("lcw_decompressor_top verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    dec_count     = '0;
    dec_limit     = 17'h10000;
    dec_phase     = lcw_pkg::PH_CMD;
    dec_kind      = lcw_pkg::K_NONE;
    dec_run       = '0;
    dec_src       = '0;
    dec_fill      = '0;
    dec_lo        = '0;
    dec_done      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_limit(17'h1FFFF);
    test_basic_commands();
    test_backpressure();
    test_random_stream(360, 0, 0, 17'h10000);
    test_random_stream(360, 83, 0, 17'($urandom_range(60000, 8192)));
    test_random_stream(360, 0, 83, 17'h0FFFF);
    test_random_stream(360, 17, 17, 17'($urandom_range(60000, 8192)));
    test_end_of_stream();

    $display("%0d input beats (%0d refused), %0d results checked, %0d bytes decoded",
             beats_sent, refused_beats, beats_checked, dec_count);
    $display({"all command kinds, overlapping copies and sink hold-off; ",
              "stream closed by %s, %0d mismatches"},
             stop_kind.name(), mismatches);
    if (mismatches == 0 && pending_beats.size() == 0)
      $display("lcw_decompressor_top verification clean");
    else
      $display("lcw_decompressor_top verification failed");
    $finish;
  end

endmodule

>>> sim.f
src/lcw_pkg.sv
src/lcw_ram.sv
src/lcw_ctrl.sv
src/lcw_ofifo.sv
src/lcw_decompressor_top.sv
verif/lcw_decompressor_top_tb.sv
